[sv/twwc_pkg.sv]
// ----------------------------------------------------------------------------
// twwc_pkg
// Shared types and codes of the trace window write checker.
// ----------------------------------------------------------------------------
package twwc_pkg;

  localparam int unsigned TypeW   = 2;
  localparam int unsigned DataW   = 64;
  localparam int unsigned FillW   = 3;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_END   = 2'd1,
    KIND_CHECK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_MATCHED   = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NEED_MORE = 3'd4
  } status_e;

  typedef struct packed {
    logic [TypeW-1:0] entry_type;
    logic [DataW-1:0] address;
    logic [DataW-1:0] data_value;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic             error_seen;
    logic [FillW-1:0] fill_count;
  } result_t;

endpackage

[sv/twwc_window.sv]
// ----------------------------------------------------------------------------
// twwc_window
// Expected-entry window with parallel match, shift-down removal and flags.
// ----------------------------------------------------------------------------
module twwc_window #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              apply_i,
  input  logic [1:0]        kind_i,
  input  twwc_pkg::entry_t  entry_i,
  output twwc_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  twwc_pkg::entry_t entry_q [Depth];
  twwc_pkg::entry_t entry_d [Depth];
  logic [CntW-1:0]  count_q, count_d;
  logic             ended_q, ended_d;
  logic             error_q, error_d;

  logic [Depth-1:0] hit;
  logic [Depth-1:0] after_hit;
  logic             full;
  logic             push_en;
  logic             drop_en;
  twwc_pkg::status_e status;
  logic [CntW+2:0]  count_ext;

  assign full = (count_q == CntW'(Depth));

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      hit[j] = (CntW'(j) < count_q) && (entry_q[j] == entry_i);
    end
    after_hit[0] = hit[0];
    for (int j = 1; j < Depth; j++) begin
      after_hit[j] = after_hit[j-1] | hit[j];
    end
  end

  always_comb begin
    status  = twwc_pkg::ST_ACCEPTED;
    push_en = 1'b0;
    drop_en = 1'b0;
    count_d = count_q;
    ended_d = ended_q;
    error_d = error_q;
    case (twwc_pkg::kind_e'(kind_i))
      twwc_pkg::KIND_PUSH: begin
        if (full) begin
          status = twwc_pkg::ST_FULL;
        end else begin
          push_en = apply_i;
          count_d = count_q + CntW'(1);
        end
      end
      twwc_pkg::KIND_END: begin
        ended_d = 1'b1;
      end
      twwc_pkg::KIND_CHECK: begin
        if (!full && !ended_q) begin
          status = twwc_pkg::ST_NEED_MORE;
        end else if (|hit) begin
          status  = twwc_pkg::ST_MATCHED;
          drop_en = apply_i;
          count_d = count_q - CntW'(1);
        end else begin
          status  = twwc_pkg::ST_MISMATCH;
          error_d = 1'b1;
        end
      end
      default: begin
        status = twwc_pkg::ST_ACCEPTED;
      end
    endcase
  end

  for (genvar j = 0; j < Depth; j++) begin : g_entry
    if (j < Depth - 1) begin : g_mid
      always_comb begin
        entry_d[j] = entry_q[j];
        if (drop_en && after_hit[j]) begin
          entry_d[j] = entry_q[j+1];
        end else if (push_en && (count_q == CntW'(j))) begin
          entry_d[j] = entry_i;
        end
      end
    end else begin : g_last
      always_comb begin
        entry_d[j] = entry_q[j];
        if (push_en && (count_q == CntW'(j))) begin
          entry_d[j] = entry_i;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      entry_q[j] <= entry_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ended_q <= 1'b0;
      error_q <= 1'b0;
    end else if (apply_i) begin
      count_q <= count_d;
      ended_q <= ended_d;
      error_q <= error_d;
    end
  end

  assign count_ext = {3'b000, count_d};

  assign result_o.status     = status;
  assign result_o.error_seen = error_d;
  assign result_o.fill_count = count_ext[2:0];

endmodule

[sv/trace_window_write_checker_top.sv]
// A transaction is held in the input register, its result in the result register.
// Throughput: one transaction per cycle unless out_stall_i holds the result; the window
// compare and the shift-down from a hit are combinational between the two registers.
// Reset: rst_ni clears the fill count, trace-end and error flags and both valid bits;
// window entries are not cleared and are read only below the fill count.
// ----------------------------------------------------------------------------
// trace_window_write_checker_top
// Checks observed writes against a window of pending expected trace entries.
// ----------------------------------------------------------------------------
module trace_window_write_checker_top #(
  parameter int unsigned WINDOW_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  entry_type_i,
  input  logic [63:0] address_i,
  input  logic [63:0] data_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        error_seen_o,
  output logic [2:0]  fill_count_o
);

  logic              in_valid_q;
  logic [1:0]        kind_q;
  twwc_pkg::entry_t  entry_q;
  logic              out_valid_q;
  twwc_pkg::result_t result_q;
  twwc_pkg::result_t result;
  logic              advance;
  logic              apply;
  logic              load;

  assign advance    = !out_valid_q || !out_stall_i;
  assign apply      = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q                <= kind_i;
      entry_q.entry_type    <= entry_type_i;
      entry_q.address       <= address_i;
      entry_q.data_value    <= data_value_i;
    end
    if (apply) begin
      result_q <= result;
    end
  end

  twwc_window #(
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (apply),
    .kind_i   (kind_q),
    .entry_i  (entry_q),
    .result_o (result)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = result_q.status;
  assign error_seen_o = result_q.error_seen;
  assign fill_count_o = result_q.fill_count;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_seen_o) |=> (!out_valid_o || error_seen_o))
    else $error("error flag cleared");

  a_mismatch_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == twwc_pkg::ST_MISMATCH)) |-> error_seen_o)
    else $error("mismatch without error flag");
`endif

endmodule

[tb/trace_window_write_checker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trace_window_write_checker_top_tb
// Drives expected-trace pushes, end marks and observed-write checks into the
// trace window write checker and compares every report against a window
// predictor kept in the testbench. Covers window extremes, out-of-order and
// duplicate matches, mismatches, the trace end, and random stalls on both
// sides.
// ----------------------------------------------------------------------------
module trace_window_write_checker_top_tb;

  localparam int unsigned Depth = 4;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [1:0] TypeReg = 2'd0;
  localparam logic [1:0] TypeMem = 2'd1;
  localparam logic [1:0] TypePc = 2'd2;
  localparam logic [1:0] TypeSpare = 2'd3;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [1:0]  entry_type_i = '0;
  logic [63:0] address_i = '0;
  logic [63:0] data_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        error_seen_o;
  logic [2:0]  fill_count_o;

  trace_window_write_checker_top #(.WINDOW_DEPTH(Depth)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .entry_type_i (entry_type_i),
    .address_i    (address_i),
    .data_value_i (data_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .error_seen_o (error_seen_o),
    .fill_count_o (fill_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // window predictor state
  logic [1:0]  win_type [Depth];
  logic [63:0] win_addr [Depth];
  logic [63:0] win_val [Depth];
  int          win_fill = 0;
  bit          trace_done = 1'b0;
  bit          sticky_err = 1'b0;

  twwc_pkg::result_t expected_reports [$];
  int      report_errors = 0;
  bit      idle_en = 1'b1;
  int      stall_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 31));
      1: return ($urandom_range(0, 1) != 0) ? AllOnes : '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic twwc_pkg::result_t advance_window(
      logic [1:0] kind, logic [1:0] etype, logic [63:0] addr, logic [63:0] val);
    twwc_pkg::result_t r;
    int      hit;
    int      i;
    r.status = twwc_pkg::ST_ACCEPTED;
    hit = -1;
    case (kind)
      twwc_pkg::KIND_PUSH: begin
        if (win_fill >= Depth) begin
          r.status = twwc_pkg::ST_FULL;
        end else begin
          win_type[win_fill] = etype;
          win_addr[win_fill] = addr;
          win_val[win_fill] = val;
          win_fill++;
        end
      end
      twwc_pkg::KIND_END: trace_done = 1'b1;
      twwc_pkg::KIND_CHECK: begin
        if (win_fill < Depth && !trace_done) begin
          r.status = twwc_pkg::ST_NEED_MORE;
        end else begin
          for (i = 0; i < win_fill; i++) begin
            if (hit < 0 && win_type[i] == etype && win_addr[i] == addr && win_val[i] == val)
              hit = i;
          end
          if (hit < 0) begin
            r.status = twwc_pkg::ST_MISMATCH;
            sticky_err = 1'b1;
          end else begin
            for (i = hit; i < win_fill - 1; i++) begin
              win_type[i] = win_type[i + 1];
              win_addr[i] = win_addr[i + 1];
              win_val[i] = win_val[i + 1];
            end
            win_fill--;
            r.status = twwc_pkg::ST_MATCHED;
          end
        end
      end
      default: ;
    endcase
    r.error_seen = sticky_err;
    r.fill_count = 3'(win_fill);
    return r;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [1:0] etype,
                           input logic [63:0] addr, input logic [63:0] val);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    entry_type_i <= etype;
    address_i <= addr;
    data_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    expected_reports.push_back(advance_window(kind, etype, addr, val));
  endtask

  task automatic push_random();
    logic [1:0] t;
    t = 2'($urandom_range(0, 3));
    send_item(twwc_pkg::KIND_PUSH, t, (t == TypePc) ? 64'd0 : rand_word(), rand_word());
  endtask

  task automatic check_entry(input int idx);
    send_item(twwc_pkg::KIND_CHECK, win_type[idx], win_addr[idx], win_val[idx]);
  endtask

  // mostly well-formed traffic: fill the window, then retire pending entries out of order
  task automatic step_wellformed(input int check_pct);
    int idx;
    if (win_fill == Depth && $urandom_range(0, 9) == 0) begin
      push_random();
    end else if (win_fill == Depth ||
                 (win_fill > 0 && $urandom_range(0, 99) < check_pct)) begin
      idx = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, win_fill - 1);
      check_entry(idx);
    end else if (win_fill > 0 && $urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, win_fill - 1);
      send_item(twwc_pkg::KIND_PUSH, win_type[idx], win_addr[idx], win_val[idx]);
    end else begin
      push_random();
    end
  endtask

  task automatic step_noise();
    int          idx;
    int          b;
    logic [1:0]  t;
    logic [63:0] a;
    logic [63:0] v;
    t = 2'($urandom_range(0, 3));
    a = rand_word();
    v = rand_word();
    case ($urandom_range(0, 3))
      0: send_item(twwc_pkg::KIND_CHECK, t, a, v);
      1: begin
        if (win_fill == 0) begin
          send_item(twwc_pkg::KIND_CHECK, t, a, v);
        end else begin
          idx = $urandom_range(0, win_fill - 1);
          t = win_type[idx];
          a = win_addr[idx];
          v = win_val[idx];
          b = $urandom_range(0, 63);
          case ($urandom_range(0, 2))
            0: t[b % 2] = ~t[b % 2];
            1: a[b] = ~a[b];
            default: v[b] = ~v[b];
          endcase
          send_item(twwc_pkg::KIND_CHECK, t, a, v);
        end
      end
      2: send_item((trace_done && $urandom_range(0, 1) != 0) ?
                   2'(twwc_pkg::KIND_END) : KindUnused, t, a, v);
      default: send_item(twwc_pkg::KIND_PUSH, t, a, v);
    endcase
  endtask

  task automatic test_fill_and_match();
    send_item(twwc_pkg::KIND_CHECK, TypeReg, 64'd5, 64'd7);
    send_item(twwc_pkg::KIND_PUSH, TypeReg, 64'd0, AllOnes);
    send_item(twwc_pkg::KIND_PUSH, TypeMem, AllOnes, 64'd0);
    send_item(twwc_pkg::KIND_PUSH, TypePc, 64'd0, 64'h8000_0000_0000_0000);
    send_item(twwc_pkg::KIND_CHECK, TypeMem, AllOnes, 64'd0);
    send_item(twwc_pkg::KIND_PUSH, TypeSpare, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA);
    send_item(twwc_pkg::KIND_PUSH, TypeReg, 64'd1, 64'd1);
    send_item(twwc_pkg::KIND_CHECK, TypePc, 64'd0, 64'h8000_0000_0000_0000);
    send_item(twwc_pkg::KIND_PUSH, TypeReg, 64'd0, AllOnes);
    send_item(twwc_pkg::KIND_CHECK, TypeReg, 64'd0, AllOnes);
    send_item(twwc_pkg::KIND_PUSH, TypeMem, 64'hAAAA_AAAA_AAAA_AAAA,
              64'h5555_5555_5555_5555);
    send_item(twwc_pkg::KIND_CHECK, TypeSpare, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA);
    send_item(twwc_pkg::KIND_PUSH, TypeReg, 64'd31, 64'd0);
    send_item(twwc_pkg::KIND_CHECK, TypeMem, AllOnes, 64'd0);
    send_item(twwc_pkg::KIND_PUSH, TypePc, 64'd0, 64'h123);
    send_item(KindUnused, TypeSpare, AllOnes, AllOnes);
  endtask

  task automatic test_reordered_stream();
    int n;
    idle_en = 1'b0;
    for (n = 0; n < 400; n++) begin
      if (n == 150) idle_en = 1'b1;
      step_wellformed(10);
    end
  endtask

  task automatic test_mismatch();
    logic [1:0]  t;
    logic [63:0] a;
    logic [63:0] v;
    while (win_fill < Depth) push_random();
    t = win_type[0];
    a = win_addr[0];
    v = win_val[0];
    send_item(twwc_pkg::KIND_CHECK, t ^ 2'd1, a, v);
    send_item(twwc_pkg::KIND_CHECK, t, a ^ 64'd1, v);
    send_item(twwc_pkg::KIND_CHECK, t, a, ~v);
    send_item(twwc_pkg::KIND_CHECK, t, a, v);
  endtask

  task automatic test_noisy_stream();
    int n;
    for (n = 0; n < 300; n++) begin
      if ($urandom_range(0, 4) == 0) step_noise();
      else step_wellformed(10);
    end
  endtask

  task automatic test_trace_end();
    send_item(twwc_pkg::KIND_END, TypeReg, 64'd0, 64'd0);
    send_item(twwc_pkg::KIND_END, TypeSpare, AllOnes, AllOnes);
    send_item(KindUnused, TypeReg, 64'd0, 64'd0);
    if (win_fill > 0) check_entry(win_fill - 1);
    while (win_fill > 0) check_entry(0);
    send_item(twwc_pkg::KIND_CHECK, TypeReg, 64'd3, 64'd9);
    send_item(twwc_pkg::KIND_PUSH, TypePc, 64'd0, AllOnes);
    send_item(twwc_pkg::KIND_CHECK, TypePc, 64'd0, AllOnes);
  endtask

  task automatic test_drain_after_end();
    int n;
    for (n = 0; n < 200; n++) begin
      if ($urandom_range(0, 3) == 0) step_noise();
      else step_wellformed(50);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else if (!idle_en) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    twwc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        report_errors++;
        if (report_errors <= 10)
          $display("unexpected report: status %0d error_seen %0b fill %0d",
                   status_o, error_seen_o, fill_count_o);
      end else begin
        want = expected_reports.pop_front();
        if (want.status !== status_o || want.error_seen !== error_seen_o ||
            want.fill_count !== fill_count_o) begin
          report_errors++;
          if (report_errors <= 10)
            $display({"report mismatch: status exp %0d got %0d, ",
                      "error_seen exp %0b got %0b, fill exp %0d got %0d"},
                     want.status, status_o, want.error_seen, error_seen_o,
                     want.fill_count, fill_count_o);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_match();
    test_reordered_stream();
    test_mismatch();
    test_noisy_stream();
    test_trace_end();
    test_drain_after_end();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (report_errors == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[trace_window_write_checker_top.f]
sv/twwc_pkg.sv
sv/twwc_window.sv
sv/trace_window_write_checker_top.sv
tb/trace_window_write_checker_top_tb.sv
